>>> rtl/core/hrf_pkg.sv
// ----------------------------------------------------------------------------
// hrf_pkg
// Types and constants shared by the HTTP response framer modules.
// ----------------------------------------------------------------------------
package hrf_pkg;

    typedef enum logic [20:0] {
        PH_PREFIX        = 21'h000001,
        PH_CODE          = 21'h000002,
        PH_LINE_REST     = 21'h000004,
        PH_LINE_LF       = 21'h000008,
        PH_HDR_START     = 21'h000010,
        PH_HDR_NAME      = 21'h000020,
        PH_HDR_SKIP      = 21'h000040,
        PH_HDR_LF        = 21'h000080,
        PH_END_LF        = 21'h000100,
        PH_CL_VALUE      = 21'h000200,
        PH_CONN_VALUE    = 21'h000400,
        PH_TE_VALUE      = 21'h000800,
        PH_BODY_FIXED    = 21'h001000,
        PH_CHUNK_SIZE    = 21'h002000,
        PH_CHUNK_EXT     = 21'h004000,
        PH_CHUNK_SIZE_LF = 21'h008000,
        PH_CHUNK_DATA    = 21'h010000,
        PH_CHUNK_CR      = 21'h020000,
        PH_CHUNK_LF      = 21'h040000,
        PH_DONE          = 21'h080000,
        PH_ERROR         = 21'h100000
    } phase_t;

    localparam logic [1:0] PS_BUSY     = 2'd0;
    localparam logic [1:0] PS_COMPLETE = 2'd1;
    localparam logic [1:0] PS_ERROR    = 2'd2;

    localparam logic [2:0] CLASS_NONE = 3'd0;
    localparam logic [2:0] CLASS_2XX  = 3'd1;
    localparam logic [2:0] CLASS_3XX  = 3'd2;
    localparam logic [2:0] CLASS_4XX  = 3'd3;
    localparam logic [2:0] CLASS_5XX  = 3'd4;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_SEMI = 8'h3b;

    function automatic logic [7:0] prefix_char(input logic [4:0] pos);
        case (pos)
            5'd0:    prefix_char = "H";
            5'd1:    prefix_char = "T";
            5'd2:    prefix_char = "T";
            5'd3:    prefix_char = "P";
            5'd4:    prefix_char = "/";
            5'd5:    prefix_char = "1";
            5'd6:    prefix_char = ".";
            5'd7:    prefix_char = "1";
            5'd8:    prefix_char = " ";
            default: prefix_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] cl_char(input logic [4:0] pos);
        case (pos)
            5'd0:    cl_char = "c";
            5'd1:    cl_char = "o";
            5'd2:    cl_char = "n";
            5'd3:    cl_char = "t";
            5'd4:    cl_char = "e";
            5'd5:    cl_char = "n";
            5'd6:    cl_char = "t";
            5'd7:    cl_char = "-";
            5'd8:    cl_char = "l";
            5'd9:    cl_char = "e";
            5'd10:   cl_char = "n";
            5'd11:   cl_char = "g";
            5'd12:   cl_char = "t";
            5'd13:   cl_char = "h";
            5'd14:   cl_char = ":";
            5'd15:   cl_char = " ";
            default: cl_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] conn_char(input logic [4:0] pos);
        case (pos)
            5'd0:    conn_char = "c";
            5'd1:    conn_char = "o";
            5'd2:    conn_char = "n";
            5'd3:    conn_char = "n";
            5'd4:    conn_char = "e";
            5'd5:    conn_char = "c";
            5'd6:    conn_char = "t";
            5'd7:    conn_char = "i";
            5'd8:    conn_char = "o";
            5'd9:    conn_char = "n";
            5'd10:   conn_char = ":";
            5'd11:   conn_char = " ";
            default: conn_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] te_char(input logic [4:0] pos);
        case (pos)
            5'd0:    te_char = "t";
            5'd1:    te_char = "r";
            5'd2:    te_char = "a";
            5'd3:    te_char = "n";
            5'd4:    te_char = "s";
            5'd5:    te_char = "f";
            5'd6:    te_char = "e";
            5'd7:    te_char = "r";
            5'd8:    te_char = "-";
            5'd9:    te_char = "e";
            5'd10:   te_char = "n";
            5'd11:   te_char = "c";
            5'd12:   te_char = "o";
            5'd13:   te_char = "d";
            5'd14:   te_char = "i";
            5'd15:   te_char = "n";
            5'd16:   te_char = "g";
            5'd17:   te_char = ":";
            5'd18:   te_char = " ";
            default: te_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input logic [4:0] pos);
        case (pos)
            5'd0:    close_char = "c";
            5'd1:    close_char = "l";
            5'd2:    close_char = "o";
            5'd3:    close_char = "s";
            5'd4:    close_char = "e";
            default: close_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ka_char(input logic [4:0] pos);
        case (pos)
            5'd0:    ka_char = "k";
            5'd1:    ka_char = "e";
            5'd2:    ka_char = "e";
            5'd3:    ka_char = "p";
            5'd4:    ka_char = "-";
            5'd5:    ka_char = "a";
            5'd6:    ka_char = "l";
            5'd7:    ka_char = "i";
            5'd8:    ka_char = "v";
            5'd9:    ka_char = "e";
            default: ka_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] chunked_char(input logic [4:0] pos);
        case (pos)
            5'd0:    chunked_char = "c";
            5'd1:    chunked_char = "h";
            5'd2:    chunked_char = "u";
            5'd3:    chunked_char = "n";
            5'd4:    chunked_char = "k";
            5'd5:    chunked_char = "e";
            5'd6:    chunked_char = "d";
            default: chunked_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

endpackage

>>> rtl/core/hrf_if.sv
// ----------------------------------------------------------------------------
// Framer channel interfaces
// Valid/ready channels for input bytes, results and the configuration write.
// ----------------------------------------------------------------------------
interface hrf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_response;

    modport source (output valid, data_byte, start_of_response, input ready);
    modport sink   (input valid, data_byte, start_of_response, output ready);
endinterface

interface hrf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] parse_status;
    logic [2:0] status_class;
    logic [9:0] status_value;
    logic       response_success;
    logic       keepalive_result;
    logic       is_chunked;
    logic       payload_byte;

    modport source (output valid, parse_status, status_class, status_value,
                    response_success, keepalive_result, is_chunked, payload_byte,
                    input ready);
    modport sink   (input valid, parse_status, status_class, status_value,
                    response_success, keepalive_result, is_chunked, payload_byte,
                    output ready);
endinterface

interface hrf_cfg_if;
    logic valid;
    logic ready;
    logic keepalive_allowed;

    modport source (output valid, keepalive_allowed, input ready);
    modport sink   (input valid, keepalive_allowed, output ready);
endinterface

>>> rtl/core/hrf_parser.sv
// ----------------------------------------------------------------------------
// hrf_parser
// Parser state registers and the next-state logic for one byte per cycle while step is high.
// ----------------------------------------------------------------------------
module hrf_parser #(
    parameter int LEN_BITS = 48
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       start_of_response,
    input  logic       keepalive_allowed,
    output logic [1:0] parse_status,
    output logic [2:0] status_class,
    output logic [9:0] status_value,
    output logic       response_success,
    output logic       keepalive_result,
    output logic       is_chunked,
    output logic       payload_byte
);

    localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

    hrf_pkg::phase_t     phase_reg, phase_next;
    logic [4:0]          pos_reg, pos_next;
    logic [2:0]          kind_reg, kind_next;
    logic [9:0]          num_reg, num_next;
    logic [2:0]          class_reg, class_next;
    logic                good_reg, good_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic                known_reg, known_next;
    logic                ka_reg, ka_next;
    logic                chunked_reg, chunked_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;
    logic [LEN_BITS-1:0] count_reg, count_next;

    hrf_pkg::phase_t     ph;
    logic [4:0]          pos;
    logic [2:0]          kind;
    logic [9:0]          num;
    logic [2:0]          cls;
    logic                good;
    logic [LEN_BITS-1:0] len;
    logic                known;
    logic                ka;
    logic                chk;
    logic [LEN_BITS-1:0] rem;
    logic [LEN_BITS-1:0] cnt;

    logic [7:0]          lc;
    logic                is_digit;
    logic [3:0]          dig;
    logic                is_hex;
    logic [3:0]          hexv;
    logic [LEN_BITS+3:0] len_x10;
    logic [LEN_BITS+3:0] len_sum;
    logic [2:0]          mask;
    logic                hit0, hit1, hit2;
    logic [9:0]          num_new;
    logic                pay;

    always_comb
    begin
        lc       = hrf_pkg::to_lower(data_byte);
        is_digit = (data_byte >= "0") && (data_byte <= "9");
        dig      = data_byte[3:0];
        is_hex   = is_digit || (lc >= "a" && lc <= "f");
        hexv     = is_digit ? data_byte[3:0] : 4'(lc[3:0] + 4'd9);

        if (start_of_response)
        begin
            ph = hrf_pkg::PH_PREFIX; pos = '0; kind = '0; num = '0; cls = '0;
            good = 1'b0; len = '0; known = 1'b0; ka = 1'b1; chk = 1'b0;
            rem = '0; cnt = '0;
        end
        else
        begin
            ph = phase_reg; pos = pos_reg; kind = kind_reg; num = num_reg;
            cls = class_reg; good = good_reg; len = len_reg; known = known_reg;
            ka = ka_reg; chk = chunked_reg; rem = rem_reg; cnt = count_reg;
        end

        phase_next = ph; pos_next = pos; kind_next = kind; num_next = num;
        class_next = cls; good_next = good; len_next = len; known_next = known;
        ka_next = ka; chunked_next = chk; rem_next = rem; count_next = cnt;
        pay = 1'b0;

        len_x10 = ({4'b0, len} << 3) + ({4'b0, len} << 1);
        len_sum = len_x10 + (LEN_BITS+4)'(dig);
        num_new = 10'(num * 10'd10 + 10'(dig));
        mask = 3'b000;
        hit0 = 1'b0; hit1 = 1'b0; hit2 = 1'b0;

        case (ph)
            hrf_pkg::PH_PREFIX:
            begin
                if (data_byte == hrf_pkg::prefix_char(pos))
                begin
                    if (pos == 5'd8)
                    begin
                        phase_next = hrf_pkg::PH_CODE; pos_next = '0;
                    end
                    else
                        pos_next = pos + 5'd1;
                end
                else
                    phase_next = hrf_pkg::PH_ERROR;
            end
            hrf_pkg::PH_CODE:
            begin
                if (!is_digit)
                    phase_next = hrf_pkg::PH_ERROR;
                else
                begin
                    num_next = num_new;
                    if (pos == 5'd2)
                    begin
                        pos_next = '0;
                        phase_next = hrf_pkg::PH_LINE_REST;
                        if (num_new >= 10'd200 && num_new < 10'd300)
                        begin
                            class_next = hrf_pkg::CLASS_2XX; good_next = 1'b1;
                        end
                        else if (num_new < 10'd400)
                        begin
                            class_next = hrf_pkg::CLASS_3XX; good_next = 1'b1;
                        end
                        else if (num_new < 10'd500)
                            class_next = hrf_pkg::CLASS_4XX;
                        else if (num_new < 10'd600)
                            class_next = hrf_pkg::CLASS_5XX;
                        else
                            phase_next = hrf_pkg::PH_ERROR;
                    end
                    else
                        pos_next = pos + 5'd1;
                end
            end
            hrf_pkg::PH_LINE_REST, hrf_pkg::PH_HDR_SKIP:
            begin
                if (data_byte == hrf_pkg::CH_CR)
                    phase_next = (ph == hrf_pkg::PH_LINE_REST) ? hrf_pkg::PH_LINE_LF
                                                               : hrf_pkg::PH_HDR_LF;
            end
            hrf_pkg::PH_LINE_LF, hrf_pkg::PH_HDR_LF:
                phase_next = (data_byte == hrf_pkg::CH_LF) ? hrf_pkg::PH_HDR_START
                                                           : hrf_pkg::PH_ERROR;
            hrf_pkg::PH_HDR_START, hrf_pkg::PH_HDR_NAME:
            begin
                if (data_byte == hrf_pkg::CH_CR)
                    phase_next = (ph == hrf_pkg::PH_HDR_START) ? hrf_pkg::PH_END_LF
                                                               : hrf_pkg::PH_HDR_LF;
                else
                begin
                    mask = (ph == hrf_pkg::PH_HDR_START) ? 3'b111 : kind;
                    if (ph == hrf_pkg::PH_HDR_START)
                        pos = '0;
                    hit0 = mask[0] && pos < 5'd16 && lc == hrf_pkg::cl_char(pos);
                    hit1 = mask[1] && pos < 5'd12 && lc == hrf_pkg::conn_char(pos);
                    hit2 = mask[2] && pos < 5'd19 && lc == hrf_pkg::te_char(pos);
                    if (hit0 && pos == 5'd15)
                    begin
                        pos_next = '0; kind_next = mask; phase_next = hrf_pkg::PH_CL_VALUE;
                        len_next = '0; known_next = 1'b1;
                    end
                    else if (hit1 && pos == 5'd11)
                    begin
                        pos_next = '0; kind_next = 3'b011;
                        phase_next = hrf_pkg::PH_CONN_VALUE;
                    end
                    else if (hit2 && pos == 5'd18)
                    begin
                        pos_next = '0; kind_next = {hit2, hit1, hit0};
                        phase_next = hrf_pkg::PH_TE_VALUE;
                    end
                    else
                    begin
                        kind_next = {hit2, hit1, hit0};
                        if ({hit2, hit1, hit0} == 3'b000)
                        begin
                            phase_next = hrf_pkg::PH_HDR_SKIP; pos_next = pos;
                        end
                        else
                        begin
                            phase_next = hrf_pkg::PH_HDR_NAME; pos_next = pos + 5'd1;
                        end
                    end
                end
            end
            hrf_pkg::PH_END_LF:
            begin
                if (data_byte != hrf_pkg::CH_LF)
                    phase_next = hrf_pkg::PH_ERROR;
                else if (chk)
                begin
                    phase_next = hrf_pkg::PH_CHUNK_SIZE; rem_next = '0;
                end
                else if (!known)
                    phase_next = hrf_pkg::PH_ERROR;
                else if (len == '0)
                    phase_next = hrf_pkg::PH_DONE;
                else
                    phase_next = hrf_pkg::PH_BODY_FIXED;
            end
            hrf_pkg::PH_CL_VALUE:
            begin
                if (data_byte == hrf_pkg::CH_CR)
                    phase_next = hrf_pkg::PH_HDR_LF;
                else if (!is_digit)
                    phase_next = hrf_pkg::PH_HDR_SKIP;
                else if (len_sum[LEN_BITS+3:LEN_BITS] != 4'd0)
                    phase_next = hrf_pkg::PH_ERROR;
                else
                    len_next = len_sum[LEN_BITS-1:0];
            end
            hrf_pkg::PH_CONN_VALUE:
            begin
                if (data_byte == hrf_pkg::CH_CR)
                    phase_next = hrf_pkg::PH_ERROR;
                else
                begin
                    hit0 = kind[0] && pos < 5'd5 && lc == hrf_pkg::close_char(pos);
                    hit1 = kind[1] && pos < 5'd10 && lc == hrf_pkg::ka_char(pos);
                    if (hit0 && pos == 5'd4)
                    begin
                        ka_next = 1'b0; phase_next = hrf_pkg::PH_HDR_SKIP;
                    end
                    else if (hit1 && pos == 5'd9)
                    begin
                        ka_next = keepalive_allowed; phase_next = hrf_pkg::PH_HDR_SKIP;
                        kind_next = {kind[2], 1'b1, hit0};
                    end
                    else
                    begin
                        kind_next = {kind[2], hit1, hit0};
                        if (!hit0 && !hit1)
                            phase_next = hrf_pkg::PH_ERROR;
                        else
                            pos_next = pos + 5'd1;
                    end
                end
            end
            hrf_pkg::PH_TE_VALUE:
            begin
                if (pos < 5'd7 && lc == hrf_pkg::chunked_char(pos))
                begin
                    if (pos == 5'd6)
                    begin
                        chunked_next = 1'b1; phase_next = hrf_pkg::PH_HDR_SKIP;
                        pos_next = '0;
                    end
                    else
                        pos_next = pos + 5'd1;
                end
                else
                    phase_next = hrf_pkg::PH_ERROR;
            end
            hrf_pkg::PH_BODY_FIXED:
            begin
                pay = 1'b1;
                count_next = cnt + LEN_ONE;
                if (cnt + LEN_ONE == len)
                    phase_next = hrf_pkg::PH_DONE;
            end
            hrf_pkg::PH_CHUNK_SIZE:
            begin
                if (data_byte == hrf_pkg::CH_CR)
                    phase_next = hrf_pkg::PH_CHUNK_SIZE_LF;
                else if (data_byte == hrf_pkg::CH_SEMI)
                    phase_next = hrf_pkg::PH_CHUNK_EXT;
                else if (!is_hex || rem[LEN_BITS-1:LEN_BITS-4] != 4'd0)
                    phase_next = hrf_pkg::PH_ERROR;
                else
                    rem_next = {rem[LEN_BITS-5:0], hexv};
            end
            hrf_pkg::PH_CHUNK_EXT:
            begin
                if (data_byte == hrf_pkg::CH_CR)
                    phase_next = hrf_pkg::PH_CHUNK_SIZE_LF;
            end
            hrf_pkg::PH_CHUNK_SIZE_LF:
            begin
                if (data_byte == hrf_pkg::CH_LF)
                    phase_next = (rem == '0) ? hrf_pkg::PH_DONE : hrf_pkg::PH_CHUNK_DATA;
                else if (data_byte != hrf_pkg::CH_CR)
                    phase_next = hrf_pkg::PH_CHUNK_EXT;
            end
            hrf_pkg::PH_CHUNK_DATA:
            begin
                pay = 1'b1;
                count_next = cnt + LEN_ONE;
                rem_next = rem - LEN_ONE;
                if (rem == LEN_ONE)
                    phase_next = hrf_pkg::PH_CHUNK_CR;
            end
            hrf_pkg::PH_CHUNK_CR:
                phase_next = (data_byte == hrf_pkg::CH_CR) ? hrf_pkg::PH_CHUNK_LF
                                                           : hrf_pkg::PH_ERROR;
            hrf_pkg::PH_CHUNK_LF:
            begin
                if (data_byte == hrf_pkg::CH_LF)
                begin
                    phase_next = hrf_pkg::PH_CHUNK_SIZE; rem_next = '0;
                end
                else
                    phase_next = hrf_pkg::PH_ERROR;
            end
            default:
                phase_next = ph;
        endcase

        if (phase_next == hrf_pkg::PH_DONE)
            parse_status = hrf_pkg::PS_COMPLETE;
        else if (phase_next == hrf_pkg::PH_ERROR)
            parse_status = hrf_pkg::PS_ERROR;
        else
            parse_status = hrf_pkg::PS_BUSY;
        status_class     = class_next;
        status_value     = (class_next != hrf_pkg::CLASS_NONE) ? num_next : 10'd0;
        response_success = (phase_next == hrf_pkg::PH_DONE) && good_next;
        keepalive_result = ka_next;
        is_chunked       = chunked_next;
        payload_byte     = pay;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= hrf_pkg::PH_PREFIX;
            pos_reg     <= '0;
            kind_reg    <= '0;
            num_reg     <= '0;
            class_reg   <= '0;
            good_reg    <= 1'b0;
            len_reg     <= '0;
            known_reg   <= 1'b0;
            ka_reg      <= 1'b1;
            chunked_reg <= 1'b0;
            rem_reg     <= '0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            kind_reg    <= kind_next;
            num_reg     <= num_next;
            class_reg   <= class_next;
            good_reg    <= good_next;
            len_reg     <= len_next;
            known_reg   <= known_next;
            ka_reg      <= ka_next;
            chunked_reg <= chunked_next;
            rem_reg     <= rem_next;
            count_reg   <= count_next;
        end
    end

endmodule

>>> rtl/core/hrf_out_stage.sv
// ----------------------------------------------------------------------------
// hrf_out_stage
// Result register with a skid register, so that in_ready comes straight from
// a register and does not depend on out_ready in the same cycle.
// ----------------------------------------------------------------------------
module hrf_out_stage (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [18:0] in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [18:0] out_data
);

    logic        main_valid_reg, skid_valid_reg;
    logic [18:0] main_data_reg, skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!main_valid_reg || out_ready)
            begin
                main_valid_reg <= skid_valid_reg || in_valid;
                skid_valid_reg <= 1'b0;
            end
            else if (in_valid && in_ready)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        else if (in_valid && in_ready)
            skid_data_reg <= in_data;
    end

endmodule

>>> rtl/core/http_response_framer.sv
// ----------------------------------------------------------------------------
// http_response_framer
// Frames an HTTP/1.1 response received one byte per beat.
// ----------------------------------------------------------------------------
// The in channel takes one response byte per beat; start_of_response on a
// beat clears the parser before that byte is parsed. Every input beat gives
// exactly one result beat on the out channel, carrying parse status, status
// class and code, keepalive and chunked flags and a payload marker.
// The cfg channel writes keepalive_allowed, which is always ready and is
// meant to be written only while no byte is in flight.
// The result of a byte is registered in the result register, or in the skid
// register while the receiver stalls. Throughput is one byte per cycle while
// the receiver does not stall. A skid register sits behind the result
// register, so when the receiver stalls the block takes one more byte and
// then drops in_ready until the result register drains.
// Reset clears the parser to the start of a status line, sets
// keepalive_allowed to one and empties the result path.
// ----------------------------------------------------------------------------
module http_response_framer #(
    parameter int LEN_BITS = 48
) (
    input  logic      clk,
    input  logic      rst_n,
    hrf_in_if.sink    in_ch,
    hrf_out_if.source out_ch,
    hrf_cfg_if.sink   cfg
);

    logic        allow_reg;
    logic        step;
    logic        in_ready;
    logic [18:0] res_data;
    logic [18:0] out_data;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = in_ready;
    assign step        = in_ch.valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            allow_reg <= 1'b1;
        else if (cfg.valid)
            allow_reg <= cfg.keepalive_allowed;
    end

    hrf_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .data_byte         (in_ch.data_byte),
        .start_of_response (in_ch.start_of_response),
        .keepalive_allowed (allow_reg),
        .parse_status      (res_data[18:17]),
        .status_class      (res_data[16:14]),
        .status_value      (res_data[13:4]),
        .response_success  (res_data[3]),
        .keepalive_result  (res_data[2]),
        .is_chunked        (res_data[1]),
        .payload_byte      (res_data[0])
    );

    hrf_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .in_data   (res_data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.parse_status     = out_data[18:17];
    assign out_ch.status_class     = out_data[16:14];
    assign out_ch.status_value     = out_data[13:4];
    assign out_ch.response_success = out_data[3];
    assign out_ch.keepalive_result = out_data[2];
    assign out_ch.is_chunked       = out_data[1];
    assign out_ch.payload_byte     = out_data[0];

endmodule

>>> rtl/core/hrf_checker.sv
// ----------------------------------------------------------------------------
// hrf_checker
// Port-level checks on the framer's result channel.
// ----------------------------------------------------------------------------
module hrf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] parse_status,
    input logic [2:0] status_class,
    input logic       response_success
);

    // A stalled result stays presented.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // After an accepted byte, a result is always presented in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted byte gave no result");

    // Success only on completed responses with a 2xx or 3xx class.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && response_success |->
            parse_status == hrf_pkg::PS_COMPLETE &&
            (status_class == hrf_pkg::CLASS_2XX || status_class == hrf_pkg::CLASS_3XX))
        else $error("success without good completion");

    // The block never refuses input while the result register is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind http_response_framer hrf_checker u_hrf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .parse_status     (out_ch.parse_status),
    .status_class     (out_ch.status_class),
    .response_success (out_ch.response_success)
);

>>> tb/tb_http_response_framer.sv
// ----------------------------------------------------------------------------
// HTTP response framer testbench
// Sends HTTP/1.1 response bytes and compares every result beat with a byte-wise
// parser kept in the testbench.
// A short byte table with known results and directed responses come first, then
// random responses: fixed length, chunked, malformed, and plain noise.
// Both channels idle at random and the receiver holds off once for a long
// stretch. keepalive_allowed is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_http_response_framer;

    localparam int LB = 48;
    localparam logic [LB-1:0] LMASK = {LB{1'b1}};

    typedef struct packed {
        logic [1:0] st;
        logic [2:0] cls;
        logic [9:0] code;
        logic       ok;
        logic       ka;
        logic       chk;
        logic       pay;
    } frame_res_t;

    typedef struct {
        logic [7:0] b;
        logic       sor;
        logic       known;
        logic [1:0] st;
    } dir_row_t;

    logic clk;
    logic rst_n;
    hrf_in_if  in_ch ();
    hrf_out_if out_ch ();
    hrf_cfg_if cfg ();

    http_response_framer #(.LEN_BITS(LB)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    hrf_pkg::phase_t ph;
    logic [4:0]     mpos;
    logic [2:0]     hkind;
    logic [9:0]     code_num;
    logic [2:0]     cls_seen;
    logic           good;
    logic [LB-1:0]  len_val;
    logic           len_known;
    logic           ka_flag;
    logic           chk_flag;
    logic [LB-1:0]  chunk_left;
    logic [LB-1:0]  body_cnt;
    logic           ka_allowed;

    frame_res_t expected_q[$];
    frame_res_t dir_expect_q[$];
    logic       dir_known_q[$];
    logic [7:0] byte_q[$];
    logic       sor_q[$];
    int         errors;
    logic       hold_off;
    logic       idle_ok;

    function automatic string hname(int k);
        case (k)
            0:       return "content-length: ";
            1:       return "connection: ";
            default: return "transfer-encoding: ";
        endcase
    endfunction

    function automatic int hexv(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [7:0] lc(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic void clear_parser();
        ph = hrf_pkg::PH_PREFIX; mpos = 0; hkind = 0; code_num = 0; cls_seen = 0;
        good = 0; len_val = 0; len_known = 0; ka_flag = 1; chk_flag = 0;
        chunk_left = 0; body_cnt = 0;
    endfunction

    function automatic void enter_body();
        if (chk_flag)
        begin
            ph = hrf_pkg::PH_CHUNK_SIZE;
            chunk_left = 0;
        end
        else if (!len_known) ph = hrf_pkg::PH_ERROR;
        else if (len_val == 0) ph = hrf_pkg::PH_DONE;
        else ph = hrf_pkg::PH_BODY_FIXED;
    endfunction

    function automatic void header_name(logic [7:0] c);
        logic [2:0] m;
        int p;
        string s;
        m = hkind;
        p = mpos;
        for (int k = 0; k < 3; k++)
        begin
            if (!m[k]) continue;
            s = hname(k);
            if (p >= s.len() || lc(c) != s[p]) m[k] = 1'b0;
            else if (p + 1 == s.len())
            begin
                mpos = 0;
                if (k == 0)
                begin
                    ph = hrf_pkg::PH_CL_VALUE;
                    len_val = 0;
                    len_known = 1;
                end
                else if (k == 1)
                begin
                    ph = hrf_pkg::PH_CONN_VALUE;
                    hkind = 3;
                end
                else ph = hrf_pkg::PH_TE_VALUE;
                return;
            end
        end
        hkind = m;
        if (m == 0) ph = hrf_pkg::PH_HDR_SKIP;
        else
        begin
            ph = hrf_pkg::PH_HDR_NAME;
            mpos = 5'(p + 1);
        end
    endfunction

    function automatic void conn_value(logic [7:0] c);
        logic [2:0] m;
        int p;
        string s;
        m = hkind;
        p = mpos;
        for (int k = 0; k < 2; k++)
        begin
            if (!m[k]) continue;
            if (k == 0) s = "close";
            else s = "keep-alive";
            if (p >= s.len() || lc(c) != s[p]) m[k] = 1'b0;
            else if (p + 1 == s.len())
            begin
                ka_flag = (k == 0) ? 1'b0 : ka_allowed;
                ph = hrf_pkg::PH_HDR_SKIP;
                return;
            end
        end
        hkind = m;
        if (m == 0) ph = hrf_pkg::PH_ERROR;
        else mpos = 5'(p + 1);
    endfunction

    function automatic frame_res_t frame_byte(logic [7:0] c, logic sor);
        frame_res_t r;
        logic pay;
        int h;
        string pre;
        string chs;
        pre = "HTTP/1.1 ";
        chs = "chunked";
        pay = 0;
        if (sor) clear_parser();
        case (ph)
            hrf_pkg::PH_PREFIX:
                if (mpos < 9 && c == pre[mpos])
                begin
                    mpos++;
                    if (mpos == 9)
                    begin
                        ph = hrf_pkg::PH_CODE;
                        mpos = 0;
                    end
                end
                else ph = hrf_pkg::PH_ERROR;
            hrf_pkg::PH_CODE:
                if (c < "0" || c > "9") ph = hrf_pkg::PH_ERROR;
                else
                begin
                    code_num = 10'(code_num * 10 + (c - "0"));
                    mpos++;
                    if (mpos >= 3)
                    begin
                        mpos = 0;
                        ph = hrf_pkg::PH_LINE_REST;
                        if (code_num >= 200 && code_num < 300)
                        begin
                            cls_seen = hrf_pkg::CLASS_2XX;
                            good = 1;
                        end
                        else if (code_num < 400)
                        begin
                            cls_seen = hrf_pkg::CLASS_3XX;
                            good = 1;
                        end
                        else if (code_num < 500) cls_seen = hrf_pkg::CLASS_4XX;
                        else if (code_num < 600) cls_seen = hrf_pkg::CLASS_5XX;
                        else ph = hrf_pkg::PH_ERROR;
                    end
                end
            hrf_pkg::PH_LINE_REST: if (c == hrf_pkg::CH_CR) ph = hrf_pkg::PH_LINE_LF;
            hrf_pkg::PH_LINE_LF, hrf_pkg::PH_HDR_LF:
                ph = (c == hrf_pkg::CH_LF) ? hrf_pkg::PH_HDR_START : hrf_pkg::PH_ERROR;
            hrf_pkg::PH_HDR_START:
                if (c == hrf_pkg::CH_CR) ph = hrf_pkg::PH_END_LF;
                else
                begin
                    hkind = 7;
                    mpos = 0;
                    header_name(c);
                end
            hrf_pkg::PH_HDR_NAME:
                if (c == hrf_pkg::CH_CR) ph = hrf_pkg::PH_HDR_LF; else header_name(c);
            hrf_pkg::PH_HDR_SKIP: if (c == hrf_pkg::CH_CR) ph = hrf_pkg::PH_HDR_LF;
            hrf_pkg::PH_END_LF:
                if (c == hrf_pkg::CH_LF) enter_body(); else ph = hrf_pkg::PH_ERROR;
            hrf_pkg::PH_CL_VALUE:
                if (c == hrf_pkg::CH_CR) ph = hrf_pkg::PH_HDR_LF;
                else if (c < "0" || c > "9") ph = hrf_pkg::PH_HDR_SKIP;
                else if (len_val > (LMASK - (c - "0")) / 10) ph = hrf_pkg::PH_ERROR;
                else len_val = len_val * 10 + (c - "0");
            hrf_pkg::PH_CONN_VALUE:
                if (c == hrf_pkg::CH_CR) ph = hrf_pkg::PH_ERROR; else conn_value(c);
            hrf_pkg::PH_TE_VALUE:
                if (mpos < 7 && lc(c) == chs[mpos])
                begin
                    mpos++;
                    if (mpos == 7)
                    begin
                        chk_flag = 1;
                        ph = hrf_pkg::PH_HDR_SKIP;
                        mpos = 0;
                    end
                end
                else ph = hrf_pkg::PH_ERROR;
            hrf_pkg::PH_BODY_FIXED:
            begin
                body_cnt = body_cnt + 1;
                if (body_cnt == len_val) ph = hrf_pkg::PH_DONE;
                pay = 1;
            end
            hrf_pkg::PH_CHUNK_SIZE:
            begin
                h = hexv(c);
                if (c == hrf_pkg::CH_CR) ph = hrf_pkg::PH_CHUNK_SIZE_LF;
                else if (c == hrf_pkg::CH_SEMI) ph = hrf_pkg::PH_CHUNK_EXT;
                else if (h < 0 || chunk_left > (LMASK >> 4)) ph = hrf_pkg::PH_ERROR;
                else chunk_left = (chunk_left << 4) | LB'(h);
            end
            hrf_pkg::PH_CHUNK_EXT:
                if (c == hrf_pkg::CH_CR) ph = hrf_pkg::PH_CHUNK_SIZE_LF;
            hrf_pkg::PH_CHUNK_SIZE_LF:
                if (c == hrf_pkg::CH_LF)
                    ph = (chunk_left == 0) ? hrf_pkg::PH_DONE : hrf_pkg::PH_CHUNK_DATA;
                else if (c != hrf_pkg::CH_CR) ph = hrf_pkg::PH_CHUNK_EXT;
            hrf_pkg::PH_CHUNK_DATA:
            begin
                body_cnt = body_cnt + 1;
                chunk_left = chunk_left - 1;
                if (chunk_left == 0) ph = hrf_pkg::PH_CHUNK_CR;
                pay = 1;
            end
            hrf_pkg::PH_CHUNK_CR:
                ph = (c == hrf_pkg::CH_CR) ? hrf_pkg::PH_CHUNK_LF : hrf_pkg::PH_ERROR;
            hrf_pkg::PH_CHUNK_LF:
                if (c == hrf_pkg::CH_LF)
                begin
                    ph = hrf_pkg::PH_CHUNK_SIZE;
                    chunk_left = 0;
                end
                else ph = hrf_pkg::PH_ERROR;
            default: ;
        endcase
        r.st = (ph == hrf_pkg::PH_DONE) ? hrf_pkg::PS_COMPLETE :
               (ph == hrf_pkg::PH_ERROR) ? hrf_pkg::PS_ERROR : hrf_pkg::PS_BUSY;
        r.cls = cls_seen;
        r.code = (cls_seen != hrf_pkg::CLASS_NONE) ? code_num : 10'd0;
        r.ok = (r.st == hrf_pkg::PS_COMPLETE) && good;
        r.ka = ka_flag;
        r.chk = chk_flag;
        r.pay = pay;
        return r;
    endfunction

    task automatic push_byte(logic [7:0] b, logic sor);
        byte_q.push_back(b);
        sor_q.push_back(sor);
        expected_q.push_back(frame_byte(b, sor));
    endtask

    task automatic push_text(string s, logic sor);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], sor && i == 0);
    endtask

    function automatic string hex_str(longint unsigned v);
        return $sformatf("%0h", v);
    endfunction

    function automatic string mix_case(string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) r[i] = r[i] - 8'd32;
        return r;
    endfunction

    function automatic string rnd_code();
        int v;
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(200, 299);
            1:       v = $urandom_range(0, 399);
            2:       v = $urandom_range(400, 499);
            3:       v = $urandom_range(500, 599);
            4:       v = $urandom_range(600, 999);
            default: v = 200;
        endcase
        return $sformatf("%03d", v);
    endfunction

    function automatic string rnd_body(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(1, 255)))};
        return s;
    endfunction

    function automatic string make_response();
        string s;
        int n;
        int nc;
        logic chunked;
        chunked = $urandom_range(0, 1);
        s = {"HTTP/1.1 ", rnd_code(), " OK\r\n"};
        if ($urandom_range(0, 2) == 0) s = {s, "X-Junk: a\r\n"};
        if ($urandom_range(0, 1))
            s = {s, mix_case("connection: "),
                 $urandom_range(0, 1) ? mix_case("close") : mix_case("keep-alive"), "\r\n"};
        n = $urandom_range(0, 6);
        if (chunked)
        begin
            s = {s, mix_case("transfer-encoding: chunked"), "\r\n\r\n"};
            nc = $urandom_range(0, 2);
            for (int k = 0; k < nc; k++)
            begin
                n = $urandom_range(1, 5);
                s = {s, hex_str(n), ($urandom_range(0, 3) == 0) ? ";x=1" : "", "\r\n",
                     rnd_body(n), "\r\n"};
            end
            s = {s, "0\r\n"};
        end
        else
            s = {s, mix_case("content-length: "), $sformatf("%0d", n), "\r\n\r\n",
                 rnd_body(n)};
        if ($urandom_range(0, 5) == 0)
            s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
        return s;
    endfunction

    task automatic drive_all();
        while (byte_q.size() > 0)
        begin
            @(negedge clk);
            if (!idle_ok || $urandom_range(0, 99) >= 10)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data_byte <= byte_q[0];
                in_ch.start_of_response <= sor_q[0];
                @(posedge clk);
                while (!in_ch.ready) @(posedge clk);
                void'(byte_q.pop_front());
                void'(sor_q.pop_front());
            end
            else
            begin
                in_ch.valid <= 1'b0;
                in_ch.data_byte <= 8'($urandom_range(0, 255));
            end
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain_and_config(logic v);
        int guard;
        guard = 0;
        while (expected_q.size() > 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.keepalive_allowed <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        ka_allowed = v;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[http_response_framer] ERROR");
        $finish;
    end

    always @(negedge clk)
        if (!rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !hold_off && (!idle_ok || $urandom_range(0, 99) >= 10);

    always @(posedge clk)
    begin
        frame_res_t want;
        frame_res_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.parse_status, out_ch.status_class, out_ch.status_value,
                    out_ch.response_success, out_ch.keepalive_result, out_ch.is_chunked,
                    out_ch.payload_byte};
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result beat %p", $time, got);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (dir_known_q.size() > 0)
                begin
                    if (dir_known_q.pop_front() && got.st != dir_expect_q[0].st)
                    begin
                        $display("%0t: table status expected %0d actual %0d", $time,
                                 dir_expect_q[0].st, got.st);
                        errors++;
                    end
                    void'(dir_expect_q.pop_front());
                end
                if (got !== want)
                begin
                    $display("%0t: expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t tbl[$];
        frame_res_t blank;
        string s;
        int n;
        errors = 0;
        hold_off = 1'b0;
        idle_ok = 1'b1;
        ka_allowed = 1'b1;
        clear_parser();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.start_of_response = 1'b0;
        cfg.valid = 1'b0;
        cfg.keepalive_allowed = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Bytes with an obvious outcome: bad first byte, byte after error,
        // restarted response, 999 status, CR not followed by LF.
        tbl = '{'{8'h00, 1'b1, 1'b1, hrf_pkg::PS_ERROR},
                '{8'hff, 1'b0, 1'b1, hrf_pkg::PS_ERROR},
                '{"H", 1'b1, 1'b1, hrf_pkg::PS_BUSY},
                '{"T", 1'b0, 1'b1, hrf_pkg::PS_BUSY}};
        blank = '0;
        foreach (tbl[i])
        begin
            push_byte(tbl[i].b, tbl[i].sor);
            dir_known_q.push_back(tbl[i].known);
            blank.st = tbl[i].st;
            dir_expect_q.push_back(blank);
        end
        push_text("HTTP/1.1 999 X", 1);
        push_text("HTTP/1.1 200 OK\r\rx", 1);
        push_text("HTTP/1.1 204 A\r\nContent-Length: 0\r\n\r\nz", 1);
        push_text("HTTP/1.1 399 A\r\nCONNECTION: Keep-Alive\r\nContent-Length: 2\r\n\r\nab", 1);
        push_text("HTTP/1.1 404 A\r\nConnection: bogus\r\n", 1);
        push_text("HTTP/1.1 500 A\r\nTransfer-Encoding: gzip\r\n", 1);
        push_text("HTTP/1.1 599 A\r\nX: y\r\n\r\n", 1);
        push_text("HTTP/1.1 200 A\r\ncontent-length: 281474976710655\r\n\r\n", 1);
        push_text("HTTP/1.1 200 A\r\ncontent-length: 281474976710656\r\n", 1);
        push_text("HTTP/1.1 200 A\r\nContent-Length: 7x\r\ncontent-length:\r\n\r\n", 1);
        push_text("HTTP/1.1 301 A\r\nTransfer-Encoding: chunked\r\n\r\n", 1);
        push_text("fffffffffffff\r\n", 0);
        push_text("HTTP/1.1 200 A\r\nTransfer-Encoding: CHUNKED\r\n\r\n", 1);
        push_text("2;ext\rq\nhiX", 0);
        push_text("HTTP/1.1 200 A\r\nTransfer-Encoding: chunked\r\n\r\nA\r\n0123456789\r\n\r\n", 1);
        push_text("HTTP/1.1 200 A\r\nTransfer-Encoding: chunked\r\n\r\ng", 1);
        drive_all();
        drain_and_config(1'b0);

        for (int ph_i = 0; ph_i < 4; ph_i++)
        begin
            n = 0;
            while (n < 70)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 1));
                    n++;
                end
                else
                begin
                    s = make_response();
                    push_text(s, 1);
                    n += s.len();
                end
            end
            idle_ok = (ph_i != 1);
            if (ph_i == 2)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            drive_all();
            drain_and_config(ph_i[0]);
        end

        n = 0;
        while (expected_q.size() > 0 && n < 100000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("[http_response_framer] OK");
        else
            $display("[http_response_framer] ERROR");
        $finish;
    end
endmodule
